### rtl/core/ppst_pkg.sv
// ----------------------------------------------------------------------------
// Plane point and segment test: shared package
// Types, constants and saturating helpers used across the plane test core.
// ----------------------------------------------------------------------------
package ppst_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NORMAL_W        = 18;
    localparam int OFFSET_W        = 32;
    localparam int TOL_W           = 16;
    localparam int ACC_W           = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_X     = 3'd0,
        REG_NORMAL_Y     = 3'd1,
        REG_NORMAL_Z     = 3'd2,
        REG_PLANE_OFFSET = 3'd3,
        REG_TOLERANCE    = 3'd4
    } t_reg_index;

    typedef enum logic [2:0] {
        REL_FRONT      = 3'd0,
        REL_BACK       = 3'd1,
        REL_ON_PLANE   = 3'd2,
        REL_IN_PLANE   = 3'd3,
        REL_PARALLEL   = 3'd4,
        REL_HIT_INSIDE = 3'd5,
        REL_HIT_OUTSIDE = 3'd6
    } t_relation;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic signed [OFFSET_W-1:0] offset;
        logic        [TOL_W-1:0]    tolerance;
    } t_plane;

    // Control word that travels with each item down the pipeline.
    typedef struct packed {
        logic      valid;
        t_relation relation;
        logic      divide;
        logic      tneg;
    } t_ctrl;

    localparam logic signed [NORMAL_W-1:0] NORMAL_Z_RESET = 18'sd65536;
    localparam logic [TOL_W-1:0]           TOL_RESET      = 16'd66;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Add two accumulator values and clip to the accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

### rtl/core/ppst_front.sv
// ----------------------------------------------------------------------------
// Plane test front end
// Direction, dot products, signed distance, denominator and classification.
// ----------------------------------------------------------------------------
module ppst_front #(
    parameter int COORD_WIDTH = ppst_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppst_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  ppst_pkg::t_plane              i_plane,
    input  logic                          i_valid,
    input  logic                          i_command,
    input  logic signed [COORD_WIDTH-1:0] i_start [3],
    input  logic signed [COORD_WIDTH-1:0] i_end   [3],
    output ppst_pkg::t_ctrl               o_ctrl,
    output logic signed [COORD_WIDTH-1:0] o_start [3],
    output logic signed [COORD_WIDTH:0]   o_dir   [3],
    output logic [ppst_pkg::ACC_W-1:0]    o_num,
    output logic [ppst_pkg::ACC_W-1:0]    o_den
);
    localparam int AW  = ppst_pkg::ACC_W;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PSW = ppst_pkg::NORMAL_W + COORD_WIDTH;
    localparam int PDW = ppst_pkg::NORMAL_W + DW;
    localparam int EW  = PDW + AW;
    localparam logic signed [EW-1:0] LIM_HI = EW'({1'b0, {(AW-1){1'b1}}});
    localparam logic signed [EW-1:0] LIM_LO = ~LIM_HI;

    function automatic logic signed [AW-1:0] clip(input logic signed [EW-1:0] v);
        if (v > LIM_HI) begin
            return LIM_HI[AW-1:0];
        end
        if (v < LIM_LO) begin
            return LIM_LO[AW-1:0];
        end
        return v[AW-1:0];
    endfunction

    // Stage 1: direction.
    logic                          r1_v, r1_cmd;
    logic signed [COORD_WIDTH-1:0] r1_s [3];
    logic signed [DW-1:0]          r1_dir [3];
    // Stage 2: products.
    logic                          r2_v, r2_cmd;
    logic signed [COORD_WIDTH-1:0] r2_s [3];
    logic signed [DW-1:0]          r2_dir [3];
    logic signed [AW-1:0]          r2_ps [3];
    logic signed [AW-1:0]          r2_pd [3];
    logic signed [AW-1:0]          r2_df;
    // Stage 3: partial sums.
    logic                          r3_v, r3_cmd;
    logic signed [COORD_WIDTH-1:0] r3_s [3];
    logic signed [DW-1:0]          r3_dir [3];
    logic signed [AW-1:0]          r3_dist_a, r3_p2, r3_den;
    // Stage 4: full distance.
    logic                          r4_v, r4_cmd;
    logic signed [COORD_WIDTH-1:0] r4_s [3];
    logic signed [DW-1:0]          r4_dir [3];
    logic signed [AW-1:0]          r4_dist, r4_den;
    // Stage 5: decision.
    ppst_pkg::t_ctrl               r5_ctrl, n5_ctrl;
    logic signed [COORD_WIDTH-1:0] r5_s [3];
    logic signed [DW-1:0]          r5_dir [3];
    logic [AW-1:0]                 r5_num, r5_den, n5_num, n5_den;

    logic signed [PSW-1:0] n2_ps [3];
    logic signed [PDW-1:0] n2_pd [3];
    logic signed [AW-1:0]  off_ext, tol, ntol;

    assign off_ext = AW'(i_plane.offset);
    assign tol     = AW'({i_plane.tolerance, FRAC_BITS'(0)});
    assign ntol    = -tol;

    always_comb begin
        n2_ps[0] = i_plane.normal_x * r1_s[0];
        n2_ps[1] = i_plane.normal_y * r1_s[1];
        n2_ps[2] = i_plane.normal_z * r1_s[2];
        n2_pd[0] = i_plane.normal_x * r1_dir[0];
        n2_pd[1] = i_plane.normal_y * r1_dir[1];
        n2_pd[2] = i_plane.normal_z * r1_dir[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd <= i_command;
            r2_cmd <= r1_cmd;
            r3_cmd <= r2_cmd;
            r4_cmd <= r3_cmd;
            for (int i = 0; i < 3; i++) begin
                r1_s[i]   <= i_start[i];
                r1_dir[i] <= DW'(i_end[i]) - DW'(i_start[i]);
                r2_s[i]   <= r1_s[i];
                r2_dir[i] <= r1_dir[i];
                r2_ps[i]  <= clip(EW'(n2_ps[i]));
                r2_pd[i]  <= clip(EW'(n2_pd[i]));
                r3_s[i]   <= r2_s[i];
                r3_dir[i] <= r2_dir[i];
                r4_s[i]   <= r3_s[i];
                r4_dir[i] <= r3_dir[i];
                r5_s[i]   <= r4_s[i];
                r5_dir[i] <= r4_dir[i];
            end
            r2_df     <= off_ext <<< FRAC_BITS;
            r3_dist_a <= ppst_pkg::sat_add(ppst_pkg::sat_add(r2_df, r2_ps[0]), r2_ps[1]);
            r3_p2     <= r2_ps[2];
            r3_den    <= ppst_pkg::sat_add(ppst_pkg::sat_add(r2_pd[0], r2_pd[1]), r2_pd[2]);
            r4_dist   <= ppst_pkg::sat_add(r3_dist_a, r3_p2);
            r4_den    <= r3_den;
            r5_num    <= n5_num;
            r5_den    <= n5_den;
        end
    end

    // Classification, parallel test and the sign and magnitudes for the divider.
    always_comb begin
        logic dist_on, hit_in;
        dist_on        = (r4_dist <= tol) && (r4_dist >= ntol);
        n5_num         = r4_dist[AW-1] ? AW'(-r4_dist) : AW'(r4_dist);
        n5_den         = r4_den[AW-1] ? AW'(-r4_den) : AW'(r4_den);
        n5_ctrl.valid  = r4_v;
        n5_ctrl.divide = 1'b0;
        n5_ctrl.tneg   = (r4_dist != '0) && (r4_dist[AW-1] == r4_den[AW-1]);
        hit_in         = (r4_dist == '0) || (!n5_ctrl.tneg && (n5_num <= n5_den));
        if (!r4_cmd) begin
            if (r4_dist > tol) begin
                n5_ctrl.relation = ppst_pkg::REL_FRONT;
            end else if (r4_dist < ntol) begin
                n5_ctrl.relation = ppst_pkg::REL_BACK;
            end else begin
                n5_ctrl.relation = ppst_pkg::REL_ON_PLANE;
            end
        end else if ((r4_den <= tol) && (r4_den >= ntol)) begin
            n5_ctrl.relation = dist_on ? ppst_pkg::REL_IN_PLANE : ppst_pkg::REL_PARALLEL;
        end else begin
            n5_ctrl.divide   = 1'b1;
            n5_ctrl.relation = hit_in ? ppst_pkg::REL_HIT_INSIDE : ppst_pkg::REL_HIT_OUTSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r5_ctrl <= n5_ctrl;
        end
    end

    assign o_ctrl  = r5_ctrl;
    assign o_start = r5_s;
    assign o_dir   = r5_dir;
    assign o_num   = r5_num;
    assign o_den   = r5_den;

endmodule

### rtl/core/ppst_div.sv
// ----------------------------------------------------------------------------
// Plane test divider
// Pipelined restoring divider: one quotient bit of t per stage.
// ----------------------------------------------------------------------------
module ppst_div #(
    parameter int COORD_WIDTH = ppst_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppst_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  ppst_pkg::t_ctrl               i_ctrl,
    input  logic signed [COORD_WIDTH-1:0] i_start [3],
    input  logic signed [COORD_WIDTH:0]   i_dir   [3],
    input  logic [ppst_pkg::ACC_W-1:0]    i_num,
    input  logic [ppst_pkg::ACC_W-1:0]    i_den,
    output ppst_pkg::t_ctrl               o_ctrl,
    output logic                          o_ovf,
    output logic [COORD_WIDTH-1:0]        o_quot,
    output logic signed [COORD_WIDTH-1:0] o_start [3],
    output logic signed [COORD_WIDTH:0]   o_dir   [3]
);
    localparam int AW = ppst_pkg::ACC_W;
    localparam int RW = AW + COORD_WIDTH + 1;
    localparam int NS = COORD_WIDTH + 1;

    ppst_pkg::t_ctrl               r_ctrl [NS];
    logic                          r_ovf  [NS];
    logic [RW-1:0]                 r_rem  [NS];
    logic [COORD_WIDTH-1:0]        r_q    [NS];
    logic [AW-1:0]                 r_den  [NS];
    logic signed [COORD_WIDTH-1:0] r_s    [NS][3];
    logic signed [COORD_WIDTH:0]   r_dir  [NS][3];

    // Entry stage: the quotient overflows COORD_WIDTH bits when
    // num * 2^FRAC_BITS >= den * 2^COORD_WIDTH.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl[0].valid <= 1'b0;
        end else if (i_en) begin
            r_ctrl[0] <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= (RW'(i_num) << FRAC_BITS) >= (RW'(i_den) << COORD_WIDTH);
            r_rem[0] <= RW'(i_num) << FRAC_BITS;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_s[0]   <= i_start;
            r_dir[0] <= i_dir;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        localparam int B = COORD_WIDTH - k;
        logic [RW:0] diff;
        assign diff = {1'b0, r_rem[k-1]} - {1'b0, RW'(r_den[k-1]) << B};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[k].valid <= 1'b0;
            end else if (i_en) begin
                r_ctrl[k] <= r_ctrl[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k]  <= r_ovf[k-1];
                r_rem[k]  <= diff[RW] ? r_rem[k-1] : diff[RW-1:0];
                r_q[k]    <= r_q[k-1] | (COORD_WIDTH'(!diff[RW]) << B);
                r_den[k]  <= r_den[k-1];
                r_s[k]    <= r_s[k-1];
                r_dir[k]  <= r_dir[k-1];
            end
        end
    end

    assign o_ctrl  = r_ctrl[NS-1];
    assign o_ovf   = r_ovf[NS-1];
    assign o_quot  = r_q[NS-1];
    assign o_start = r_s[NS-1];
    assign o_dir   = r_dir[NS-1];

endmodule

### rtl/core/ppst_back.sv
// ----------------------------------------------------------------------------
// Plane test back end
// Signed, saturated t, then the hit point start + dir * t with clipping.
// ----------------------------------------------------------------------------
module ppst_back #(
    parameter int COORD_WIDTH = ppst_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppst_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  ppst_pkg::t_ctrl               i_ctrl,
    input  logic                          i_ovf,
    input  logic [COORD_WIDTH-1:0]        i_quot,
    input  logic signed [COORD_WIDTH-1:0] i_start [3],
    input  logic signed [COORD_WIDTH:0]   i_dir   [3],
    output ppst_pkg::t_ctrl               o_ctrl,
    output logic signed [COORD_WIDTH-1:0] o_cross [3],
    output logic                          o_sat
);
    localparam int AW = ppst_pkg::ACC_W;
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = DW + COORD_WIDTH;
    localparam int EW = PW + AW;
    localparam logic signed [EW-1:0] LIM_HI = EW'({1'b0, {(AW-1){1'b1}}});
    localparam logic signed [EW-1:0] LIM_LO = ~LIM_HI;
    localparam logic [COORD_WIDTH-1:0] T_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] T_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [AW:0] CMAX =
        {{(AW-COORD_WIDTH+2){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [AW:0] CMIN = ~CMAX;

    function automatic logic signed [AW-1:0] clip(input logic signed [EW-1:0] v);
        if (v > LIM_HI) begin
            return LIM_HI[AW-1:0];
        end
        if (v < LIM_LO) begin
            return LIM_LO[AW-1:0];
        end
        return v[AW-1:0];
    endfunction

    ppst_pkg::t_ctrl               r1_ctrl, r2_ctrl, r3_ctrl;
    logic signed [COORD_WIDTH-1:0] r1_t;
    logic                          r1_sat, r2_sat, r3_sat;
    logic signed [COORD_WIDTH-1:0] r1_s [3], r2_s [3];
    logic signed [DW-1:0]          r1_dir [3];
    logic signed [AW-1:0]          r2_prod [3];
    logic signed [COORD_WIDTH-1:0] r3_cross [3], n3_cross [3];
    logic                          n3_sat;

    logic [COORD_WIDTH-1:0] lim, tm;
    logic                   tclip;
    logic signed [PW-1:0]   n2_prod [3];

    assign lim   = i_ctrl.tneg ? T_NEG : T_POS;
    assign tclip = i_ovf || (i_quot > lim);
    assign tm    = tclip ? lim : i_quot;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_prod[i] = r1_dir[i] * r1_t;
        end
    end

    always_comb begin
        logic signed [AW:0] v;
        n3_sat = r2_sat;
        for (int i = 0; i < 3; i++) begin
            v = (AW+1)'(r2_s[i]) + (AW+1)'(r2_prod[i] >>> FRAC_BITS);
            if (v > CMAX) begin
                v      = CMAX;
                n3_sat = 1'b1;
            end else if (v < CMIN) begin
                v      = CMIN;
                n3_sat = 1'b1;
            end
            n3_cross[i] = r2_ctrl.divide ? v[COORD_WIDTH-1:0] : '0;
        end
        n3_sat = n3_sat && r2_ctrl.divide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl.valid <= 1'b0;
            r2_ctrl.valid <= 1'b0;
            r3_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r1_ctrl <= i_ctrl;
            r2_ctrl <= r1_ctrl;
            r3_ctrl <= r2_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t     <= i_ctrl.tneg ? -tm : tm;
            r1_sat   <= tclip;
            r1_s     <= i_start;
            r1_dir   <= i_dir;
            r2_sat   <= r1_sat;
            r2_s     <= r1_s;
            for (int i = 0; i < 3; i++) begin
                r2_prod[i] <= clip(EW'(n2_prod[i]));
            end
            r3_sat   <= n3_sat;
            r3_cross <= n3_cross;
        end
    end

    assign o_ctrl  = r3_ctrl;
    assign o_cross = r3_cross;
    assign o_sat   = r3_sat;

endmodule

### rtl/core/plane_point_and_segment_test.sv
// ----------------------------------------------------------------------------
// Plane point and segment test
// Classifies points against a configured plane and intersects segments
// with it, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The divider contributes one stage per bit of t, plus an entry stage.
// Throughput: one transfer per cycle on each side while the output drains.
// Reset (synchronous, active low) empties the pipeline and loads the plane
// registers with normal (0, 0, 1.0), offset 0 and tolerance 66.
module plane_point_and_segment_test #(
    parameter int COORD_WIDTH = ppst_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppst_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration writes: index selects one of the five plane registers.
    input  logic                               i_cfg_we,
    input  logic [ppst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ppst_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: start_x, start_y, start_z, end_x, end_y, end_z, zero padding
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // tuser: command
    input  logic [0:0]                         i_s_tuser,
    // Result stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: cross_x, cross_y, cross_z, zero padding
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // tuser: relation (3 bits), saturated
    output logic [3:0]                         o_m_tuser
);
    localparam int OUT_DW = ((3*COORD_WIDTH+7)/8)*8;

    ppst_pkg::t_plane r_plane;

    // Plane registers. Writes to indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane.normal_x  <= '0;
            r_plane.normal_y  <= '0;
            r_plane.normal_z  <= ppst_pkg::NORMAL_Z_RESET;
            r_plane.offset    <= '0;
            r_plane.tolerance <= ppst_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            case (ppst_pkg::t_reg_index'(i_cfg_index))
                ppst_pkg::REG_NORMAL_X: begin
                    r_plane.normal_x <= i_cfg_data[ppst_pkg::NORMAL_W-1:0];
                end
                ppst_pkg::REG_NORMAL_Y: begin
                    r_plane.normal_y <= i_cfg_data[ppst_pkg::NORMAL_W-1:0];
                end
                ppst_pkg::REG_NORMAL_Z: begin
                    r_plane.normal_z <= i_cfg_data[ppst_pkg::NORMAL_W-1:0];
                end
                ppst_pkg::REG_PLANE_OFFSET: begin
                    r_plane.offset <= i_cfg_data[ppst_pkg::OFFSET_W-1:0];
                end
                ppst_pkg::REG_TOLERANCE: begin
                    r_plane.tolerance <= i_cfg_data[ppst_pkg::TOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances together. It only has to hold when the
    // output register is occupied and not taken while the last pipeline
    // stage carries a result; otherwise bubbles are squeezed out and new
    // transfers keep entering even though a result waits at the output.
    logic pipe_en;

    logic signed [COORD_WIDTH-1:0] in_start [3];
    logic signed [COORD_WIDTH-1:0] in_end   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_start[i] = i_s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
            in_end[i]   = i_s_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    ppst_pkg::t_ctrl               front_ctrl, div_ctrl, back_ctrl;
    logic signed [COORD_WIDTH-1:0] front_start [3], div_start [3];
    logic signed [COORD_WIDTH:0]   front_dir [3], div_dir [3];
    logic [ppst_pkg::ACC_W-1:0]    front_num, front_den;
    logic                          div_ovf;
    logic [COORD_WIDTH-1:0]        div_quot;
    logic signed [COORD_WIDTH-1:0] back_cross [3];
    logic                          back_sat;

    // Distance, denominator and classification: five stages.
    ppst_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_plane   (r_plane),
        .i_valid   (i_s_tvalid),
        .i_command (i_s_tuser[0]),
        .i_start   (in_start),
        .i_end     (in_end),
        .o_ctrl    (front_ctrl),
        .o_start   (front_start),
        .o_dir     (front_dir),
        .o_num     (front_num),
        .o_den     (front_den)
    );

    // t = -dist / den: COORD_WIDTH + 1 stages.
    ppst_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_ctrl  (front_ctrl),
        .i_start (front_start),
        .i_dir   (front_dir),
        .i_num   (front_num),
        .i_den   (front_den),
        .o_ctrl  (div_ctrl),
        .o_ovf   (div_ovf),
        .o_quot  (div_quot),
        .o_start (div_start),
        .o_dir   (div_dir)
    );

    // Hit point: three stages.
    ppst_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_ctrl  (div_ctrl),
        .i_ovf   (div_ovf),
        .i_quot  (div_quot),
        .i_start (div_start),
        .i_dir   (div_dir),
        .o_ctrl  (back_ctrl),
        .o_cross (back_cross),
        .o_sat   (back_sat)
    );

    // Output register.
    logic                          r_m_valid;
    ppst_pkg::t_relation           r_rel;
    logic signed [COORD_WIDTH-1:0] r_cross [3];
    logic                          r_sat;
    logic                          out_load;

    assign out_load   = !r_m_valid || i_m_tready;
    assign pipe_en    = out_load || !back_ctrl.valid;
    assign o_s_tready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= back_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_rel   <= back_ctrl.relation;
            r_cross <= back_cross;
            r_sat   <= back_sat;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_DW'({r_cross[2], r_cross[1], r_cross[0]});
    assign o_m_tuser  = {r_sat, r_rel};

`ifndef ASSERT_OFF
    // Point results and non-crossing segment results carry no hit point.
    a_no_hit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_rel == ppst_pkg::REL_FRONT || r_rel == ppst_pkg::REL_BACK ||
                       r_rel == ppst_pkg::REL_ON_PLANE || r_rel == ppst_pkg::REL_IN_PLANE ||
                       r_rel == ppst_pkg::REL_PARALLEL))
        |-> (r_cross[0] == '0 && r_cross[1] == '0 && r_cross[2] == '0 && !r_sat))
        else $error("non-hit result carries hit point or saturation");

    // A result waiting at the output is never overwritten by the pipeline.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_tready) |=> (r_m_valid && $stable(r_rel) && $stable(r_sat)))
        else $error("stalled result changed");

    // Reset leaves no result at the output.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid after reset");
`endif

endmodule
